@@ rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the running median filter
// window depth, field widths and the structs passed along the row of cells
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int AGE_W      = IDX_W;
    localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
    localparam int SAMPLE_W   = 32;
    localparam int MED_W      = SAMPLE_W + 1;
    localparam int CFG_W      = 6;
    localparam int WIN_RESET  = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MED_W-1:0]    median_t;
    typedef logic [AGE_W-1:0]           age_t;
    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [FILL_W-1:0]          fill_t;
    typedef logic [CFG_W-1:0]           cfg_t;

    // broadcast to every cell
    typedef struct packed {
        logic    en;     // update the row this cycle
        logic    ins;    // insert the new item (clear: remove only)
        sample_t x;      // new sample
        fill_t   fill;   // number of occupied cells
        age_t    tgt;    // age of the entry that leaves
        idx_t    med_a;  // lower middle position
        idx_t    med_b;  // upper middle position
    } ctl_t;

    // handed from a cell to its right neighbour
    typedef struct packed {
        sample_t val;
        age_t    age;
        logic    kle;    // cell stays at or below the insertion point
        logic    rl;     // leaving entry is here or further left
    } rlink_t;

    // handed from a cell to its left neighbour
    typedef struct packed {
        sample_t val;
        age_t    age;
        logic    le;     // occupied and not above the new sample
    } llink_t;

endpackage

@@ rtl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// holds a value and its age, shifts left or right by one or takes the new item
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic            clk,
    input  swm_pkg::idx_t   cell_idx,
    input  swm_pkg::ctl_t   ctl,
    input  logic            rle,
    input  swm_pkg::rlink_t from_left,
    input  swm_pkg::llink_t from_right,
    output swm_pkg::rlink_t to_right,
    output swm_pkg::llink_t to_left,
    output logic            rh_le,
    output swm_pkg::sample_t med_a_val,
    output swm_pkg::sample_t med_b_val
);

    swm_pkg::sample_t val_reg;
    swm_pkg::sample_t val_next;
    swm_pkg::age_t    age_reg;
    swm_pkg::age_t    age_next;
    logic             occupied;
    logic             le;
    logic             rh;
    logic             rl;
    logic             kle;
    logic             at;

    always_comb
    begin
        occupied = ({1'b0, cell_idx} < {1'b0, ctl.fill});
        le       = occupied && ($signed(val_reg) <= $signed(ctl.x));
        rh       = occupied && (age_reg == ctl.tgt);
        rl       = from_left.rl | rh;
        kle      = !ctl.ins | (rle ? from_right.le : le);
        at       = !kle & from_left.kle;

        if (at)
        begin
            val_next = ctl.x;
            age_next = '0;
        end
        else if (kle)
        begin
            // below the insertion point: close the gap of the leaving entry
            val_next = rl ? from_right.val : val_reg;
            age_next = rl ? from_right.age : age_reg;
        end
        else
        begin
            // above the insertion point: make room
            val_next = from_left.rl ? val_reg : from_left.val;
            age_next = from_left.rl ? age_reg : from_left.age;
        end
        if (ctl.ins && !at)
        begin
            age_next = age_next + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign to_right  = '{val: val_reg, age: age_reg, kle: kle, rl: rl};
    assign to_left   = '{val: val_reg, age: age_reg, le: le};
    assign rh_le     = rh & le;
    assign med_a_val = (cell_idx == ctl.med_a) ? val_reg : '0;
    assign med_b_val = (cell_idx == ctl.med_b) ? val_reg : '0;

endmodule

@@ rtl/sliding_window_median.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median: running median over the last window_size samples
// a row of cells keeps the window sorted, each entry tagged with its age
// ----------------------------------------------------------------------------
// usage
//   input channel: sample and restart, moved by in_valid / in_stall
//   output channel: median_doubled, moved by out_valid / out_stall
//   config: cfg_wr_en with cfg_wr_data writes window_size (0 acts as 1,
//   above the row length acts as the row length), only while idle
//   one item is taken per cycle while in_stall is low; an item first updates
//   the row, then the middle read and add puts its result into the output
//   register
//   no result until window_size items have arrived since reset or restart
//   after window_size is made smaller, the row drops one surplus entry per
//   cycle while no parked result is held by out_stall, with in_stall high
//   reset empties the window, clears out_valid and sets window_size to 3
//   when out_stall holds a result, items that complete no window are still
//   taken; the next item that completes a window is parked in the read
//   stage, and in_stall then stays high until the output drains
// ----------------------------------------------------------------------------
module sliding_window_median (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  swm_pkg::sample_t      sample,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output swm_pkg::median_t      median_doubled,
    input  logic                  cfg_wr_en,
    input  swm_pkg::cfg_t         cfg_wr_data
);

    swm_pkg::cfg_t    win_reg;
    swm_pkg::fill_t   fill_reg;
    swm_pkg::fill_t   fill_next;
    logic             pend_reg;
    logic             pend_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    swm_pkg::median_t med_reg;
    swm_pkg::median_t med_next;

    swm_pkg::fill_t   k;
    swm_pkg::fill_t   fill_eff;
    swm_pkg::fill_t   fill_step;
    logic             drop_busy;
    logic             pend_block;
    logic             pend_go;
    logic             accept;
    logic             rle;
    swm_pkg::ctl_t    ctl;
    swm_pkg::sample_t mid_a;
    swm_pkg::sample_t mid_b;

    swm_pkg::rlink_t  rlnk [0:swm_pkg::WINDOW_MAX];
    swm_pkg::llink_t  llnk [0:swm_pkg::WINDOW_MAX];
    logic [swm_pkg::WINDOW_MAX-1:0] rh_le_vec;
    swm_pkg::sample_t med_a_vals [swm_pkg::WINDOW_MAX];
    swm_pkg::sample_t med_b_vals [swm_pkg::WINDOW_MAX];

    // effective window size, clamped into 1 .. row length
    always_comb
    begin
        if (win_reg == '0)
        begin
            k = swm_pkg::FILL_W'(1);
        end
        else if (int'(win_reg) > swm_pkg::WINDOW_MAX)
        begin
            k = swm_pkg::FILL_W'(swm_pkg::WINDOW_MAX);
        end
        else
        begin
            k = swm_pkg::FILL_W'(win_reg);
        end
    end

    // surplus entries after the window shrank leave one per cycle unless a parked result is stalled
    assign drop_busy  = (fill_reg > k);
    assign pend_block = pend_reg && out_valid_reg && out_stall;
    assign pend_go    = pend_reg && !(out_valid_reg && out_stall);
    assign in_stall   = drop_busy || pend_block;
    assign accept     = in_valid && !in_stall;

    assign fill_eff  = restart ? '0 : fill_reg;
    // ages are always 0 .. fill-1, so the entry of age k-1 exists when full
    assign fill_step = fill_eff - swm_pkg::FILL_W'(fill_eff == k) + 1'b1;

    always_comb
    begin
        ctl.en  = accept || (drop_busy && !pend_block);
        ctl.ins = !drop_busy;
        ctl.x   = sample;
        if (drop_busy)
        begin
            ctl.fill = fill_reg;
            ctl.tgt  = swm_pkg::AGE_W'(fill_reg - 1'b1);
        end
        else
        begin
            ctl.fill = fill_eff;
            ctl.tgt  = swm_pkg::AGE_W'(k - 1'b1);
        end
        // middle positions: both the same for an odd window
        if (k[0])
        begin
            ctl.med_a = swm_pkg::IDX_W'((k - 1'b1) >> 1);
            ctl.med_b = swm_pkg::IDX_W'((k - 1'b1) >> 1);
        end
        else
        begin
            ctl.med_a = swm_pkg::IDX_W'((k >> 1) - 1'b1);
            ctl.med_b = swm_pkg::IDX_W'(k >> 1);
        end
    end

    // row boundaries: nothing leaves left of cell 0, nothing is right of the end
    assign rlnk[0]                   = '{val: '0, age: '0, kle: 1'b1, rl: 1'b0};
    assign llnk[swm_pkg::WINDOW_MAX] = '{val: '0, age: '0, le: 1'b0};

    for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++)
    begin : g_cell
        swm_cell u_cell (
            .clk        (clk),
            .cell_idx   (swm_pkg::IDX_W'(i)),
            .ctl        (ctl),
            .rle        (rle),
            .from_left  (rlnk[i]),
            .from_right (llnk[i+1]),
            .to_right   (rlnk[i+1]),
            .to_left    (llnk[i]),
            .rh_le      (rh_le_vec[i]),
            .med_a_val  (med_a_vals[i]),
            .med_b_val  (med_b_vals[i])
        );
    end

    // leaving entry sits below the insertion point
    assign rle = |rh_le_vec;

    // one-hot pick of the two middle cells
    always_comb
    begin
        mid_a = '0;
        mid_b = '0;
        for (int i = 0; i < swm_pkg::WINDOW_MAX; i++)
        begin
            mid_a = mid_a | med_a_vals[i];
            mid_b = mid_b | med_b_vals[i];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            fill_next = fill_step;
        end
        else if (drop_busy && !pend_block)
        begin
            fill_next = fill_reg - 1'b1;
        end

        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = (fill_step == k);
        end
        else if (pend_go)
        begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        med_next       = med_reg;
        if (pend_go)
        begin
            out_valid_next = 1'b1;
            med_next       = {mid_a[swm_pkg::SAMPLE_W-1], mid_a}
                           + {mid_b[swm_pkg::SAMPLE_W-1], mid_b};
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= swm_pkg::CFG_W'(swm_pkg::WIN_RESET);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                win_reg <= cfg_wr_data;
            end
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        med_reg <= med_next;
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = med_reg;

endmodule

@@ rtl/swm_checker.sv @@
// ----------------------------------------------------------------------------
// swm_checker: port-level checks of the running median filter
// watches the handshakes and the reset behaviour at the top level
// ----------------------------------------------------------------------------
module swm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input swm_pkg::median_t median_doubled
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median_doubled))
        else $error("stalled result changed");

    // a new result follows an accepted item
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without an accepted item");

    // reset leaves no result and an open input
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("state not cleared by reset");

    // a result only goes away once it has been taken
    a_out_leave: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without being taken");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .median_doubled (median_doubled)
);

@@ tb/sv/sliding_window_median_test.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_test: self-checking bench for the running median
// a driver feeds samples from a queue, a monitor checks every median against
// an in-bench sorted window with age tags, across several window sizes
// ----------------------------------------------------------------------------
module sliding_window_median_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    CLK_HALF      = 2;
    localparam int    RESET_CYCLES  = 7;
    // margin for items that give no median to settle in the row
    localparam int    SETTLE_CYCLES = 8;
    localparam int    PRINT_LIMIT   = 40;
    // watchdog limit, far above the slowest correct run
    localparam time   TIMEOUT_NS    = 2_000_000;

    // one item of the input channel
    typedef struct {
        swm_pkg::sample_t value;
        logic             rs;
    } sample_item_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    swm_pkg::sample_t sample      = '0;
    logic             restart     = 1'b0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    swm_pkg::median_t median_doubled;
    logic             cfg_wr_en   = 1'b0;
    swm_pkg::cfg_t    cfg_wr_data = '0;

    // items still to be offered, and medians still to arrive
    sample_item_t     samples_pending[$];
    swm_pkg::median_t median_due[$];

    // bookkeeping shared by driver, monitor and sequencer
    int samples_queued = 0;
    int samples_taken  = 0;
    int mismatches     = 0;
    int in_idle_pct    = 0;
    int out_idle_pct   = 0;
    int in_gap         = 0;
    int out_gap        = 0;

    // bench copy of the window: ascending values, each with its age
    swm_pkg::sample_t win_val[swm_pkg::WINDOW_MAX];
    int               win_age[swm_pkg::WINDOW_MAX];
    int               win_fill = 0;
    swm_pkg::cfg_t    win_cfg  = swm_pkg::cfg_t'(swm_pkg::WIN_RESET);

    sliding_window_median dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .median_doubled (median_doubled),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // window predictor: age, drop the old, insert sorted, report twice median
    // ------------------------------------------------------------------------
    function automatic void predict_median(input swm_pkg::sample_t x, input logic rs);
        int k;
        int kept;
        int pos;
        int i;
        swm_pkg::median_t m;
        // a size of zero acts as one, above the row length it is clamped
        if (win_cfg == 0)
            k = 1;
        else if (win_cfg > swm_pkg::WINDOW_MAX)
            k = swm_pkg::WINDOW_MAX;
        else
            k = int'(win_cfg);
        if (rs)
            win_fill = 0;
        // age everything, keep only what still fits in k samples
        kept = 0;
        for (i = 0; i < win_fill; i++)
        begin
            if (win_age[i] + 1 < k)
            begin
                win_val[kept] = win_val[i];
                win_age[kept] = win_age[i] + 1;
                kept++;
            end
        end
        win_fill = kept;
        // new sample goes after any equal values
        pos = 0;
        while (pos < win_fill && win_val[pos] <= x)
            pos++;
        for (i = win_fill; i > pos; i--)
        begin
            win_val[i] = win_val[i-1];
            win_age[i] = win_age[i-1];
        end
        win_val[pos] = x;
        win_age[pos] = 0;
        win_fill++;
        // lower and upper middle coincide for an odd window
        if (win_fill >= k)
        begin
            m = swm_pkg::median_t'(win_val[(k-1)/2]) + swm_pkg::median_t'(win_val[k/2]);
            median_due.insert(median_due.size(), m);
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued items, holds them while stalled, idles in bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_samples
        logic         nxt_valid;
        sample_item_t it;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                // item taken: predict from the payload just accepted
                predict_median(sample, restart);
                samples_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct)
                    in_gap = $urandom_range(1, 7) - 1;
                else if (samples_pending.size() > 0)
                begin
                    it = samples_pending.pop_front();
                    sample    <= it.value;
                    restart   <= it.rs;
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each median taken, stalls the output in bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_medians
        swm_pkg::median_t want;
        logic             nxt_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (median_due.size() == 0)
                    report_mismatch($sformatf("median %0d with none expected",
                                              median_doubled));
                else
                begin
                    want = median_due.pop_front();
                    if (median_doubled !== want)
                        report_mismatch($sformatf("median_doubled %0d, expected %0d",
                                                  median_doubled, want));
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                nxt_stall = 1'b1;
            end
            else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct)
            begin
                out_gap   = $urandom_range(1, 7) - 1;
                nxt_stall = 1'b1;
            end
            else
                nxt_stall = 1'b0;
            out_stall <= nxt_stall;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer helpers
    // ------------------------------------------------------------------------
    task automatic queue_sample(input swm_pkg::sample_t v, input logic rs);
        sample_item_t it;
        it.value = v;
        it.rs    = rs;
        samples_pending.insert(samples_pending.size(), it);
        samples_queued++;
    endtask

    // mix of full-range values, tight clusters for ties, and the extremes
    function automatic swm_pkg::sample_t pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return swm_pkg::sample_t'($urandom);
            4, 5, 6:    return swm_pkg::sample_t'(int'($urandom_range(0, 16)) - 8);
            7:          return $urandom_range(0, 1) ? swm_pkg::sample_t'(32'h7fff_ffff)
                                                    : swm_pkg::sample_t'(32'h8000_0000);
            8:          return swm_pkg::sample_t'(32'h7fff_fff0 + $urandom_range(0, 15));
            default:    return swm_pkg::sample_t'(32'h8000_0000 + $urandom_range(0, 15));
        endcase
    endfunction

    // everything offered is taken, every median is in, the row has settled
    task automatic wait_drained();
        while (samples_taken != samples_queued || median_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only ever issued while the block is idle
    task automatic write_window(input swm_pkg::cfg_t v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        win_cfg     = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input int win, input int count, input int in_pct,
                             input int out_pct, input int rs_pct);
        int n;
        wait_drained();
        write_window(swm_pkg::cfg_t'(win));
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        for (n = 0; n < count; n++)
            queue_sample(pick_sample(), $urandom_range(0, 99) < rs_pct);
    endtask

    // ------------------------------------------------------------------------
    // stimulus: directed extremes, then random phases over many window sizes
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of three: extremes, overflow of the doubling, ties
        in_idle_pct  = 20;
        out_idle_pct = 20;
        queue_sample(swm_pkg::sample_t'(32'h7fff_ffff), 1'b1);
        queue_sample(swm_pkg::sample_t'(32'h7fff_ffff), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h7fff_ffff), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h8000_0000), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h8000_0000), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h8000_0000), 1'b0);
        queue_sample(swm_pkg::sample_t'(0), 1'b0);
        queue_sample(swm_pkg::sample_t'(-1), 1'b0);
        queue_sample(swm_pkg::sample_t'(1), 1'b0);
        // restart mid-stream: no median until the window refills
        queue_sample(swm_pkg::sample_t'(5), 1'b1);
        queue_sample(swm_pkg::sample_t'(5), 1'b0);
        queue_sample(swm_pkg::sample_t'(5), 1'b0);
        // equal values around the middle
        queue_sample(swm_pkg::sample_t'(7), 1'b0);
        queue_sample(swm_pkg::sample_t'(7), 1'b0);
        queue_sample(swm_pkg::sample_t'(-7), 1'b0);

        // even window: sum of the two middles at both ends of the range
        wait_drained();
        write_window(swm_pkg::cfg_t'(2));
        queue_sample(swm_pkg::sample_t'(32'h7fff_ffff), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h8000_0000), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h7fff_ffff), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h7fff_ffff), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h8000_0000), 1'b0);
        queue_sample(swm_pkg::sample_t'(32'h8000_0000), 1'b0);
        queue_sample(swm_pkg::sample_t'(3), 1'b1);
        queue_sample(swm_pkg::sample_t'(-4), 1'b0);

        // random phases; sizes 0 and 63 exercise the clamping, changes without
        // restart check growing and shrinking windows mid-stream
        run_phase(1,  150, 25, 25, 5);
        run_phase(32, 160, 15, 30, 1);
        run_phase(0,  150, 30, 10, 5);
        run_phase(63, 160, 0,  0,  1);
        run_phase(2,  150, 20, 20, 5);
        run_phase(17, 150, 10, 35, 1);
        run_phase(6,  150, 35, 15, 3);
        run_phase(33, 160, 15, 15, 1);
        run_phase(5,  150, 25, 25, 3);
        run_phase(32, 160, 20, 20, 1);
        run_phase(4,  150, 20, 20, 3);
        // final stretch runs flat out on both sides
        run_phase(3,  150, 0,  0,  2);

        wait_drained();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sliding_window_median.f @@
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_median.sv
rtl/swm_checker.sv
tb/sv/sliding_window_median_test.sv
